>>> rtl/core/duri_pkg.sv
// Shared types, codes and character lookups for the data URI payload decoder.
package duri_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } duri_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] status;
    logic       out_last;
  } duri_out_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_B64 = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_BAD_HEX = 2'd3
  } duri_status_e;

  localparam logic ModePercent = 1'b0;
  localparam logic ModeBase64  = 1'b1;

  localparam logic [7:0] CharPad     = 8'h3d;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharSpace   = 8'h20;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic       mode;
    logic       last;
    logic [7:0] chr;
    logic       skip;
    logic       pad;
    logic       pct;
    logic       b64_ok;
    logic [5:0] b64_val;
    logic       hex_ok;
    logic [3:0] hex_val;
  } duri_cls_t;

  function automatic logic [6:0] b64_lookup(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h00;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2f) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  function automatic logic [4:0] hex_lookup(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/duri_front.sv
// Front end: mode register, item intake and character classification.
module duri_front import duri_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  input  duri_in_t  in_item_i,
  output logic      in_stall_o,
  input  logic      full_i,
  output logic      push_o,
  output duri_cls_t cls_o
);

  logic       mode_q;
  logic [6:0] b64_res;
  logic [4:0] hex_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePercent;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  assign b64_res    = b64_lookup(in_item_i.in_char);
  assign hex_res    = hex_lookup(in_item_i.in_char);
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cls_o.mode    = mode_q;
    cls_o.last    = in_item_i.in_last;
    cls_o.chr     = in_item_i.in_char;
    cls_o.skip    = (in_item_i.in_char == CharSpace) ||
                    (in_item_i.in_char inside {[8'h09:8'h0d]});
    cls_o.pad     = (in_item_i.in_char == CharPad);
    cls_o.pct     = (in_item_i.in_char == CharPercent);
    cls_o.b64_ok  = b64_res[6];
    cls_o.b64_val = b64_res[5:0];
    cls_o.hex_ok  = hex_res[4];
    cls_o.hex_val = hex_res[3:0];
  end

endmodule

>>> rtl/core/duri_fifo.sv
// Short queue of classified items between front and back ends.
module duri_fifo import duri_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  duri_cls_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output duri_cls_t data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  duri_cls_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

>>> rtl/core/duri_back.sv
// Back end: base64 and percent decode state, error latch and output register.
module duri_back import duri_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  duri_cls_t item_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output duri_out_t out_item_o,
  input  logic      out_stall_i
);

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_HI   = 3'b010,
    ESC_LO   = 3'b100
  } esc_e;

  logic [11:0]  acc_q, acc_d, acc_new, shifted;
  logic [2:0]   pend_q, pend_d, shamt;
  logic [3:0]   pend_sum;
  logic         pad_q, pad_d;
  esc_e         esc_q, esc_d;
  logic [3:0]   hi_q, hi_d;
  logic         bad_q, bad_d;
  duri_status_e err_q, err_d;
  logic [7:0]   byte_v;
  logic         vld_v;
  logic         out_vld_q;
  duri_out_t    out_q;

  assign pop_o       = !empty_i && (!out_vld_q || !out_stall_i);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign acc_new     = {acc_q[5:0], item_i.b64_val};
  assign pend_sum    = {1'b0, pend_q} + 4'd6;
  assign shamt       = 3'(pend_sum - 4'd8);
  assign shifted     = acc_new >> shamt;

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    pad_d  = pad_q;
    esc_d  = esc_q;
    hi_d   = hi_q;
    bad_d  = bad_q;
    err_d  = err_q;
    byte_v = 8'h00;
    vld_v  = 1'b0;
    if (pop_o && err_q == ST_OK) begin
      if (item_i.mode == ModeBase64) begin
        if (pad_q || item_i.skip) begin
          pad_d = pad_q;
        end else if (item_i.pad) begin
          pad_d = 1'b1;
        end else if (!item_i.b64_ok) begin
          err_d = ST_BAD_B64;
        end else begin
          acc_d = acc_new;
          if (pend_sum >= 4'd8) begin
            byte_v = shifted[7:0];
            vld_v  = 1'b1;
            pend_d = shamt;
          end else begin
            pend_d = pend_sum[2:0];
          end
        end
      end else begin
        case (esc_q)
          ESC_IDLE: begin
            if (item_i.pct) begin
              if (item_i.last) begin
                err_d = ST_TRUNC;
              end else begin
                esc_d = ESC_HI;
              end
            end else begin
              byte_v = item_i.chr;
              vld_v  = 1'b1;
            end
          end
          ESC_HI: begin
            if (item_i.last) begin
              err_d = ST_TRUNC;
            end else begin
              bad_d = !item_i.hex_ok;
              hi_d  = item_i.hex_ok ? item_i.hex_val : 4'h0;
              esc_d = ESC_LO;
            end
          end
          ESC_LO: begin
            if (bad_q || !item_i.hex_ok) begin
              err_d = ST_BAD_HEX;
            end else begin
              byte_v = {hi_q, item_i.hex_val};
              vld_v  = 1'b1;
            end
            esc_d = ESC_IDLE;
            bad_d = 1'b0;
            hi_d  = 4'h0;
          end
          default: begin
            esc_d = ESC_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      pend_q    <= '0;
      pad_q     <= 1'b0;
      esc_q     <= ESC_IDLE;
      hi_q      <= '0;
      bad_q     <= 1'b0;
      err_q     <= ST_OK;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        out_vld_q <= 1'b1;
        if (item_i.last) begin
          acc_q  <= '0;
          pend_q <= '0;
          pad_q  <= 1'b0;
          esc_q  <= ESC_IDLE;
          hi_q   <= '0;
          bad_q  <= 1'b0;
          err_q  <= ST_OK;
        end else begin
          acc_q  <= acc_d;
          pend_q <= pend_d;
          pad_q  <= pad_d;
          esc_q  <= esc_d;
          hi_q   <= hi_d;
          bad_q  <= bad_d;
          err_q  <= err_d;
        end
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.out_byte  <= byte_v;
      out_q.out_valid <= vld_v;
      out_q.status    <= err_d;
      out_q.out_last  <= item_i.last;
    end
  end

  a_pend_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q[0])
    else $error("odd pending bit count");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.last |=> pend_q == '0 && err_q == ST_OK && esc_q == ESC_IDLE && !pad_q)
    else $error("state not cleared after last item");

  a_err_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status != ST_OK |-> !out_q.out_valid)
    else $error("byte emitted with error status");

endmodule

>>> rtl/core/data_uri_payload_decoder.sv
// Top level of the data URI payload decoder (base64 or percent escapes).
//   Channel   Direction  Handshake                Payload
//   in        input      in_valid_i / in_stall_o   in_item_i  (char, last)
//   out       output     out_valid_o / out_stall_i out_item_o (byte, valid, status, last)
//   cfg       input      cfg_we_i                  cfg_data_i (mode)
// One item per cycle unless stalled; items are queued, then held in the output register.
// The two-entry queue between intake and decode, plus the output register,
// lets intake continue while a result waits under out_stall_i.
// Reset clears the mode register to percent decoding and all decode state.
// The decode state also clears after each item marked last.
module data_uri_payload_decoder import duri_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  input  duri_in_t  in_item_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output duri_out_t out_item_o,
  input  logic      out_stall_i
);

  logic      push, pop, full, empty;
  duri_cls_t cls_in, cls_out;

  duri_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .cls_o      (cls_in)
  );

  duri_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cls_out),
    .empty_o (empty)
  );

  duri_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (cls_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the data URI payload decoder: directed table plus random payloads.
module tb_top;
  import duri_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EscIdle = 0;
  localparam int EscHigh = 1;
  localparam int EscLow  = 2;
  localparam int MaxPrints = 30;

  typedef struct packed {
    logic       mode;
    logic [7:0] chr;
    logic       last;
    logic       chk;
    duri_out_t  want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_data_i = 1'b0;
  logic      in_valid_i = 1'b0;
  duri_in_t  in_item_i = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  duri_out_t out_item_o;
  logic      out_stall_i = 1'b0;

  int cyc = 0;
  wire calm = (cyc >= 1200 && cyc < 2200);

  // Decoder shadow state
  logic         cur_mode = ModePercent;
  logic [11:0]  acc;
  int           pend;
  logic         pad_hit;
  int           esc_phase;
  logic [3:0]   hi_nib;
  logic         first_bad;
  duri_status_e err_code;
  logic         skipped;

  duri_out_t pending_results [$];
  duri_out_t head;
  logic [7:0] pay_q [$];

  int err_count = 0;
  int chars_sent = 0;
  int decoded_chars = 0;
  int results_checked = 0;
  int mode_writes = 0;

  dir_row_t dir_table [25] = '{
    '{ModePercent, 8'h41, 1'b0, 1'b1, '{8'h41, 1'b1, ST_OK, 1'b0}},
    '{ModePercent, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, ST_OK, 1'b0}},
    '{ModePercent, 8'hff, 1'b0, 1'b1, '{8'hff, 1'b1, ST_OK, 1'b0}},
    '{ModePercent, 8'h25, 1'b0, 1'b0, '0},
    '{ModePercent, 8'h66, 1'b0, 1'b0, '0},
    '{ModePercent, 8'h46, 1'b1, 1'b1, '{8'hff, 1'b1, ST_OK, 1'b1}},
    '{ModePercent, 8'h25, 1'b1, 1'b1, '{8'h00, 1'b0, ST_TRUNC, 1'b1}},
    '{ModePercent, 8'h25, 1'b0, 1'b0, '0},
    '{ModePercent, 8'h67, 1'b0, 1'b0, '0},
    '{ModePercent, 8'h30, 1'b0, 1'b1, '{8'h00, 1'b0, ST_BAD_HEX, 1'b0}},
    '{ModePercent, 8'h41, 1'b1, 1'b1, '{8'h00, 1'b0, ST_BAD_HEX, 1'b1}},
    '{ModePercent, 8'h25, 1'b0, 1'b0, '0},
    '{ModePercent, 8'h67, 1'b1, 1'b1, '{8'h00, 1'b0, ST_TRUNC, 1'b1}},
    '{ModeBase64,  8'h54, 1'b0, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{ModeBase64,  8'h20, 1'b0, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b0}},
    '{ModeBase64,  8'h57, 1'b0, 1'b0, '0},
    '{ModeBase64,  8'h0d, 1'b0, 1'b0, '0},
    '{ModeBase64,  8'h2f, 1'b0, 1'b0, '0},
    '{ModeBase64,  8'h3d, 1'b0, 1'b0, '0},
    '{ModeBase64,  8'h21, 1'b1, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b1}},
    '{ModeBase64,  8'h2a, 1'b1, 1'b1, '{8'h00, 1'b0, ST_BAD_B64, 1'b1}},
    '{ModeBase64,  8'h2b, 1'b0, 1'b0, '0},
    '{ModePercent, 8'h37, 1'b0, 1'b0, '0},
    '{ModeBase64,  8'h2f, 1'b1, 1'b0, '0},
    '{ModeBase64,  8'h0e, 1'b1, 1'b1, '{8'h00, 1'b0, ST_BAD_B64, 1'b1}}
  };

  data_uri_payload_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 6);
  end

  function automatic int b64_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return int'(c) - 8'h41;
    if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 8'h61 + 26;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30 + 52;
    if (c == 8'h2b) return 62;
    if (c == 8'h2f) return 63;
    return -1;
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] b64_char(input int v);
    if (v < 26) return 8'h41 + 8'(v);
    if (v < 52) return 8'h61 + 8'(v - 26);
    if (v < 62) return 8'h30 + 8'(v - 52);
    if (v == 62) return 8'h2b;
    return 8'h2f;
  endfunction

  function automatic logic [7:0] hex_char(input int v, input bit upper);
    if (v < 10) return 8'h30 + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v - 10);
  endfunction

  function automatic void clear_decoder();
    acc       = '0;
    pend      = 0;
    pad_hit   = 1'b0;
    esc_phase = EscIdle;
    hi_nib    = '0;
    first_bad = 1'b0;
    err_code  = ST_OK;
  endfunction

  function automatic duri_out_t decode_char(input logic [7:0] c, input logic last);
    duri_out_t r;
    int d;
    int h;
    r = '0;
    skipped = 1'b0;
    if (err_code == ST_OK) begin
      if (cur_mode == ModeBase64) begin
        if (pad_hit || c == CharSpace || (c >= 8'h09 && c <= 8'h0d)) begin
          skipped = 1'b1;
        end else if (c == CharPad) begin
          pad_hit = 1'b1;
        end else begin
          d = b64_value(c);
          if (d < 0) begin
            err_code = ST_BAD_B64;
          end else begin
            acc = {acc[5:0], 6'(d)};
            pend = pend + 6;
            if (pend >= 8) begin
              r.out_byte  = 8'(acc >> (pend - 8));
              r.out_valid = 1'b1;
              pend = pend - 8;
            end
          end
        end
      end else begin
        case (esc_phase)
          EscIdle: begin
            if (c == CharPercent) begin
              if (last) err_code = ST_TRUNC;
              else esc_phase = EscHigh;
            end else begin
              r.out_byte  = c;
              r.out_valid = 1'b1;
            end
          end
          EscHigh: begin
            if (last) begin
              err_code = ST_TRUNC;
            end else begin
              h = hex_value(c);
              first_bad = (h < 0);
              hi_nib = (h < 0) ? 4'h0 : 4'(h);
              esc_phase = EscLow;
            end
          end
          default: begin
            h = hex_value(c);
            if (first_bad || h < 0) begin
              err_code = ST_BAD_HEX;
            end else begin
              r.out_byte  = {hi_nib, 4'(h)};
              r.out_valid = 1'b1;
            end
            esc_phase = EscIdle;
            first_bad = 1'b0;
            hi_nib    = '0;
          end
        endcase
      end
    end
    r.status   = err_code;
    r.out_last = last;
    if (last) clear_decoder();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MaxPrints) begin
      $display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $realtime, results_checked,
               what, got, want);
    end
    err_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", int'(out_item_o), 0);
      end else begin
        head = pending_results.pop_front();
        if (out_item_o.out_byte != head.out_byte)
          report_mismatch("out_byte", int'(out_item_o.out_byte), int'(head.out_byte));
        if (out_item_o.out_valid != head.out_valid)
          report_mismatch("out_valid", int'(out_item_o.out_valid), int'(head.out_valid));
        if (out_item_o.status != head.status)
          report_mismatch("status", int'(out_item_o.status), int'(head.status));
        if (out_item_o.out_last != head.out_last)
          report_mismatch("out_last", int'(out_item_o.out_last), int'(head.out_last));
      end
      results_checked++;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last, input logic chk,
                           input duri_out_t want);
    duri_out_t pred;
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = '{in_char: c, in_last: last};
    pred = decode_char(c, last);
    pending_results = {pending_results, (chk ? want : pred)};
    chars_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = m;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cur_mode = m;
    mode_writes++;
  endtask

  initial begin
    int n;
    int kind;
    int roll;
    int flip;
    logic [7:0] spaces [6];
    spaces = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    clear_decoder();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_mode(ModePercent);

    foreach (dir_table[i]) begin
      if (dir_table[i].mode != cur_mode) begin
        drain();
        write_mode(dir_table[i].mode);
      end
      send_char(dir_table[i].chr, dir_table[i].last, dir_table[i].chk, dir_table[i].want);
    end

    while (decoded_chars < 850) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_mode(!cur_mode);
      end
      pay_q.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) pay_q = {pay_q, 8'($urandom_range(0, 255))};
      end else if (cur_mode == ModeBase64) begin
        n = $urandom_range(1, 16);
        repeat (n) begin
          if ($urandom_range(0, 19) == 0) pay_q = {pay_q, spaces[$urandom_range(0, 5)]};
          if ($urandom_range(0, 39) == 0) pay_q = {pay_q, 8'($urandom_range(0, 255))};
          pay_q = {pay_q, b64_char($urandom_range(0, 63))};
        end
        roll = $urandom_range(0, 3);
        if (roll <= 1) pay_q = {pay_q, CharPad};
        if (roll == 1) begin
          pay_q = {pay_q, CharPad};
          if ($urandom_range(0, 1) == 1) pay_q = {pay_q, 8'($urandom_range(0, 255))};
        end
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          roll = $urandom_range(0, 99);
          if (roll < 70) begin
            pay_q = {pay_q, 8'($urandom_range(0, 255))};
          end else if (roll < 95) begin
            pay_q = {pay_q, CharPercent};
            pay_q = {pay_q, hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1)))};
            pay_q = {pay_q, hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1)))};
          end else begin
            pay_q = {pay_q, CharPercent};
            pay_q = {pay_q, 8'($urandom_range(0, 255))};
            pay_q = {pay_q, 8'($urandom_range(0, 255))};
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          pay_q = {pay_q, CharPercent};
          if ($urandom_range(0, 1) == 1)
            pay_q = {pay_q, hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1)))};
        end
      end
      flip = -1;
      if (pay_q.size() > 1 && $urandom_range(0, 19) == 0)
        flip = $urandom_range(1, pay_q.size() - 1);
      foreach (pay_q[k]) begin
        if (k == flip) begin
          drain();
          write_mode(!cur_mode);
        end
        send_char(pay_q[k], k == pay_q.size() - 1, 1'b0, '0);
        if (!skipped) decoded_chars++;
      end
    end

    drain();
    $display("Sent %0d characters (%0d decoded, not skipped), checked %0d results.",
             chars_sent, decoded_chars, results_checked);
    $display("Mode register written %0d times, including mid-payload switches.", mode_writes);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
